// ===== hdl/safc_pkg.sv =====
package safc_pkg;

   localparam int ADDR_W = 16;
   localparam int DATA_W = 8;
   localparam int CNT_W  = 32;

   localparam int SETS_DEF       = 8;
   localparam int WAYS_DEF       = 4;
   localparam int LINE_BYTES_DEF = 64;
   localparam int MEM_BYTES_DEF  = 65536;

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_CMP   = 7'b0000100,
      ST_WR    = 7'b0001000,
      ST_FILL  = 7'b0010000,
      ST_RD    = 7'b0100000,
      ST_DONE  = 7'b1000000
   } safc_state_type;

   typedef struct packed {
      logic clear_step;
      logic accept;
      logic compare;
      logic write_op;
      logic fill_step;
      logic line_rd;
      logic load_rsp;
   } safc_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic is_write;
      logic hit_now;
      logic fill_last;
      logic rsp_free;
   } safc_status_type;

endpackage

// ===== hdl/safc_ctrl.sv =====
module safc_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  safc_pkg::safc_status_type status,
   output safc_pkg::safc_cmd_type    cmd
);
   import safc_pkg::*;

   safc_state_type state_ff;
   safc_state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_CMP;
            end
         end
         ST_CMP: begin
            cmd.compare = 1'b1;
            if (status.is_write) begin
               state_in = ST_WR;
            end else if (status.hit_now) begin
               state_in = ST_RD;
            end else begin
               state_in = ST_FILL;
            end
         end
         ST_WR: begin
            cmd.write_op = 1'b1;
            state_in     = ST_DONE;
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (status.fill_last) begin
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            cmd.line_rd = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

`ifndef NO_ASSERTIONS
   // The last fill beat can only be seen while the controller is filling.
   a_fill_last_in_fill: assert property (@(posedge clock) disable iff (reset)
      (status.fill_last |-> state_ff == ST_FILL))
      else $error("fill completion outside fill state");

   // A transaction is taken only after the memory clearing pass is over.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR |-> !req_ready))
      else $error("request accepted during clearing pass");
`endif

endmodule

// ===== hdl/safc_dp.sv =====
module safc_dp #(
   parameter int SETS       = safc_pkg::SETS_DEF,
   parameter int WAYS       = safc_pkg::WAYS_DEF,
   parameter int LINE_BYTES = safc_pkg::LINE_BYTES_DEF,
   parameter int MEM_BYTES  = safc_pkg::MEM_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_mode,
   input  logic [safc_pkg::ADDR_W-1:0]   req_address,
   input  logic [safc_pkg::DATA_W-1:0]   req_write_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [safc_pkg::DATA_W-1:0]   rsp_read_data,
   output logic                          rsp_hit,
   output logic [safc_pkg::CNT_W-1:0]    rsp_access_total,
   output logic [safc_pkg::CNT_W-1:0]    rsp_miss_total,
   input  safc_pkg::safc_cmd_type        cmd,
   output safc_pkg::safc_status_type     status
);
   import safc_pkg::*;

   localparam int OFF_W   = $clog2(LINE_BYTES);
   localparam int SET_RAW = $clog2(SETS);
   localparam int SET_W   = (SET_RAW > 0) ? SET_RAW : 1;
   localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int TAG_RAW = ADDR_W - OFF_W - SET_RAW;
   localparam int TAG_W   = (TAG_RAW > 0) ? TAG_RAW : 1;
   localparam int MEM_AW  = $clog2(MEM_BYTES);
   localparam int LD_AW   = SET_W + WAY_W + OFF_W;

   // Storage.
   logic [DATA_W-1:0]            back_mem [MEM_BYTES];
   logic [DATA_W-1:0]            line_mem [2**LD_AW];
   logic [WAYS-1:0][TAG_W-1:0]   tag_mem  [SETS];
   logic [SETS-1:0][WAYS-1:0]    valid_ff;
   logic [SETS-1:0][WAY_W-1:0]   fifo_ff;

   // Request and lookup registers.
   logic                         mode_ff;
   logic [ADDR_W-1:0]            addr_ff;
   logic [DATA_W-1:0]            wdata_ff;
   logic [WAYS-1:0][TAG_W-1:0]   tag_row_ff;
   logic                         hit_ff;
   logic                         full_ff;
   logic [WAY_W-1:0]             way_ff;
   logic [CNT_W-1:0]             access_ff;
   logic [CNT_W-1:0]             miss_ff;

   // Clearing pass and line fill.
   logic [MEM_AW-1:0]            clr_cnt_ff;
   logic [OFF_W:0]               fill_cnt_ff;
   logic                         fill_pend_ff;
   logic [OFF_W-1:0]             fill_idx_ff;

   logic [DATA_W-1:0]            mem_rdata_ff;
   logic [DATA_W-1:0]            ld_rdata_ff;

   // Result register.
   logic                         rsp_valid_ff;
   logic [DATA_W-1:0]            rsp_read_data_ff;
   logic                         rsp_hit_ff;
   logic [CNT_W-1:0]             rsp_access_ff;
   logic [CNT_W-1:0]             rsp_miss_ff;

   logic [SET_W-1:0]             in_set;
   logic [SET_W-1:0]             cur_set;
   logic [OFF_W-1:0]             cur_off;
   logic [TAG_W-1:0]             cur_tag;
   logic [WAYS-1:0]              match;
   logic                         hit_now;
   logic [WAY_W-1:0]             hit_way;
   logic                         has_empty;
   logic [WAY_W-1:0]             empty_way;
   logic [WAYS-1:0][TAG_W-1:0]   tag_row_in;
   logic                         fill_last;

   logic                         mem_we;
   logic                         mem_re;
   logic [MEM_AW-1:0]            mem_addr;
   logic [DATA_W-1:0]            mem_wdata;
   logic                         ld_we;
   logic [LD_AW-1:0]             ld_waddr;
   logic [DATA_W-1:0]            ld_wdata;
   logic [LD_AW-1:0]             ld_raddr;

   assign in_set  = SET_W'((req_address >> OFF_W) % SETS);
   assign cur_set = SET_W'((addr_ff >> OFF_W) % SETS);
   assign cur_off = OFF_W'(addr_ff % LINE_BYTES);
   assign cur_tag = TAG_W'(addr_ff >> (OFF_W + SET_RAW));

   // Tag compare over the ways of the set, lowest matching way wins.
   always_comb begin
      hit_now   = 1'b0;
      hit_way   = '0;
      has_empty = 1'b0;
      empty_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         match[w] = valid_ff[cur_set][w] && (tag_row_ff[w] == cur_tag);
         if (match[w]) begin
            hit_now = 1'b1;
            hit_way = WAY_W'(w);
         end
         if (!valid_ff[cur_set][w]) begin
            has_empty = 1'b1;
            empty_way = WAY_W'(w);
         end
      end
   end

   assign fill_last = fill_pend_ff && (fill_idx_ff == OFF_W'(LINE_BYTES - 1));

   always_comb begin
      tag_row_in         = tag_row_ff;
      tag_row_in[way_ff] = cur_tag;
   end

   // Backing memory port: clearing pass, write-through, or line fill reads.
   always_comb begin
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = clr_cnt_ff;
      mem_wdata = '0;
      if (cmd.clear_step) begin
         mem_we = 1'b1;
      end else if (cmd.write_op) begin
         mem_we    = 1'b1;
         mem_addr  = MEM_AW'(addr_ff);
         mem_wdata = wdata_ff;
      end else if (cmd.fill_step) begin
         mem_re   = !fill_cnt_ff[OFF_W];
         mem_addr = MEM_AW'({addr_ff[ADDR_W-1:OFF_W], fill_cnt_ff[OFF_W-1:0]});
      end
   end

   always_comb begin
      ld_we    = fill_pend_ff || (cmd.write_op && hit_ff);
      ld_waddr = fill_pend_ff ? {cur_set, way_ff, fill_idx_ff} : {cur_set, way_ff, cur_off};
      ld_wdata = fill_pend_ff ? mem_rdata_ff : wdata_ff;
      ld_raddr = {cur_set, way_ff, cur_off};
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         back_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= back_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ld_we) begin
         line_mem[ld_waddr] <= ld_wdata;
      end
      if (cmd.line_rd) begin
         ld_rdata_ff <= line_mem[ld_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         tag_row_ff <= tag_mem[in_set];
      end
      if (cmd.fill_step && fill_last) begin
         tag_mem[cur_set] <= tag_row_in;
      end
   end

   // Payload registers of the transaction in flight.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff  <= req_mode;
         addr_ff  <= req_address;
         wdata_ff <= req_write_data;
      end
      if (cmd.compare) begin
         hit_ff  <= hit_now;
         full_ff <= !has_empty;
         if (hit_now) begin
            way_ff <= hit_way;
         end else if (has_empty) begin
            way_ff <= empty_way;
         end else begin
            way_ff <= fifo_ff[cur_set];
         end
      end
      if (fill_pend_ff || cmd.fill_step) begin
         fill_idx_ff <= fill_cnt_ff[OFF_W-1:0];
      end
      if (cmd.load_rsp) begin
         rsp_read_data_ff <= mode_ff ? '0 : ld_rdata_ff;
         rsp_hit_ff       <= hit_ff;
         rsp_access_ff    <= access_ff;
         rsp_miss_ff      <= miss_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         fifo_ff      <= '0;
         access_ff    <= '0;
         miss_ff      <= '0;
         clr_cnt_ff   <= '0;
         fill_cnt_ff  <= '0;
         fill_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_step) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
         if (cmd.compare) begin
            access_ff   <= access_ff + 1'b1;
            miss_ff     <= miss_ff + CNT_W'(!hit_now);
            fill_cnt_ff <= '0;
         end else if (mem_re) begin
            fill_cnt_ff <= fill_cnt_ff + 1'b1;
         end
         fill_pend_ff <= mem_re;
         if (cmd.fill_step && fill_last) begin
            valid_ff[cur_set][way_ff] <= 1'b1;
            if (full_ff) begin
               fifo_ff[cur_set] <= (way_ff == WAY_W'(WAYS - 1)) ? '0 : way_ff + 1'b1;
            end
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.clear_done = (clr_cnt_ff == MEM_AW'(MEM_BYTES - 1));
   assign status.is_write   = mode_ff;
   assign status.hit_now    = hit_now;
   assign status.fill_last  = fill_last;
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_read_data_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_access_total = rsp_access_ff;
   assign rsp_miss_total   = rsp_miss_ff;

`ifndef NO_ASSERTIONS
   // Fill writes and write-through updates share the line memory write port.
   a_line_port_excl: assert property (@(posedge clock) disable iff (reset)
      !(fill_pend_ff && cmd.write_op))
      else $error("line memory write port conflict");

   // A new result never overwrites one that has not been taken.
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready)))
      else $error("result register overwritten");

   // Miss count never runs ahead of the access count by a step.
   a_miss_step: assert property (@(posedge clock) disable iff (reset)
      (cmd.compare |=> (miss_ff - $past(miss_ff)) <= (access_ff - $past(access_ff))))
      else $error("miss counter advanced without an access");
`endif

endmodule

// ===== hdl/set_assoc_cache_fifo_core.sv =====
// Writes and read hits go from acceptance through the compare state and a write or line
// read state to the done state, which loads the result register once the result port is
// free; the next transaction is accepted after the return to idle. A read miss adds a
// line fill, one backing memory read per byte. One transaction is in progress at a time;
// a finished result waits in an output register while the next transaction is accepted
// and processed. After reset the backing memory is cleared one byte per cycle, all
// MEM_BYTES bytes (65536 by default), before the first transaction is accepted.
module set_assoc_cache_fifo_core #(
   parameter int SETS       = safc_pkg::SETS_DEF,
   parameter int WAYS       = safc_pkg::WAYS_DEF,
   parameter int LINE_BYTES = safc_pkg::LINE_BYTES_DEF,
   parameter int MEM_BYTES  = safc_pkg::MEM_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_mode,
   input  logic [safc_pkg::ADDR_W-1:0]   req_address,
   input  logic [safc_pkg::DATA_W-1:0]   req_write_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [safc_pkg::DATA_W-1:0]   rsp_read_data,
   output logic                          rsp_hit,
   output logic [safc_pkg::CNT_W-1:0]    rsp_access_total,
   output logic [safc_pkg::CNT_W-1:0]    rsp_miss_total
);
   import safc_pkg::*;

   safc_cmd_type    cmd;
   safc_status_type status;

   safc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   safc_dp #(
      .SETS       (SETS),
      .WAYS       (WAYS),
      .LINE_BYTES (LINE_BYTES),
      .MEM_BYTES  (MEM_BYTES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_mode         (req_mode),
      .req_address      (req_address),
      .req_write_data   (req_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_data    (rsp_read_data),
      .rsp_hit          (rsp_hit),
      .rsp_access_total (rsp_access_total),
      .rsp_miss_total   (rsp_miss_total),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

// ===== tb/set_assoc_cache_fifo_core_test.sv =====
module set_assoc_cache_fifo_core_test;
   import safc_pkg::*;

   localparam int N_SETS    = SETS_DEF;
   localparam int N_WAYS    = WAYS_DEF;
   localparam int LINE_LEN  = LINE_BYTES_DEF;
   localparam int MEM_LEN   = MEM_BYTES_DEF;
   localparam int OFF_W     = $clog2(LINE_LEN);
   localparam int SET_W     = $clog2(N_SETS);
   localparam int TAG_W     = ADDR_W - OFF_W - SET_W;

   localparam int RANDOM_ITEMS = 1900;
   localparam int TAGS_PER_SET = 6;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 200;
   localparam int MAX_REPORTS  = 10;
   // Pressure points and the stretch without idling on either side.
   localparam int HOLD_AT      = 400;
   localparam int HOLD_CYCLES  = 400;
   localparam int PAUSE_AT     = 900;
   localparam int QUIET_LO     = 1200;
   localparam int QUIET_HI     = 1500;

   typedef enum bit {
      OP_READ  = 1'b0,
      OP_WRITE = 1'b1
   } op_type;

   typedef struct {
      op_type            op;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } access_item_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              hit;
      logic [CNT_W-1:0]  access_total;
      logic [CNT_W-1:0]  miss_total;
   } access_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_mode = 1'b0;
   logic [ADDR_W-1:0]   req_address = '0;
   logic [DATA_W-1:0]   req_write_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [DATA_W-1:0]   rsp_read_data;
   logic                rsp_hit;
   logic [CNT_W-1:0]    rsp_access_total;
   logic [CNT_W-1:0]    rsp_miss_total;

   // Shadow copy of the cache and its backing memory.
   logic [DATA_W-1:0]   shadow_mem [MEM_LEN];
   logic [DATA_W-1:0]   line_bytes [N_SETS][N_WAYS][LINE_LEN];
   logic [TAG_W-1:0]    line_tag [N_SETS][N_WAYS];
   bit                  line_valid [N_SETS][N_WAYS];
   int                  evict_ptr [N_SETS];
   logic [CNT_W-1:0]    access_cnt = '0;
   logic [CNT_W-1:0]    miss_cnt = '0;

   access_item_type     pending_q [$];
   access_result_type   expected_q [$];

   int                  n_offered = 0;
   int                  n_accepted = 0;
   int                  n_checked = 0;
   int                  n_taken = 0;
   int                  n_reads = 0;
   int                  n_writes = 0;
   int                  n_hits = 0;
   int                  n_evictions = 0;
   int                  error_count = 0;
   int                  cycle_count = 0;
   int                  hold_left = 0;
   bit                  hold_done = 1'b0;

   set_assoc_cache_fifo_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_address      (req_address),
      .req_write_data   (req_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_data    (rsp_read_data),
      .rsp_hit          (rsp_hit),
      .rsp_access_total (rsp_access_total),
      .rsp_miss_total   (rsp_miss_total)
   );

   always #5 clock = ~clock;

   function automatic logic [ADDR_W-1:0] byte_addr(int tag, int set_idx, int offs);
      byte_addr = {TAG_W'(tag), SET_W'(set_idx), OFF_W'(offs)};
   endfunction

   // One cache access: FIFO replacement on read misses, write-through with
   // no allocation on write misses.
   function automatic access_result_type cache_access(op_type op, logic [ADDR_W-1:0] addr,
                                                      logic [DATA_W-1:0] data);
      access_result_type r;
      logic [OFF_W-1:0]  offs;
      logic [SET_W-1:0]  set_idx;
      logic [TAG_W-1:0]  tag;
      logic [ADDR_W-1:0] base;
      int                hit_way;
      int                victim;
      int                w;
      int                k;
      offs    = addr[OFF_W-1:0];
      set_idx = addr[OFF_W +: SET_W];
      tag     = addr[ADDR_W-1 -: TAG_W];
      base    = addr - offs;
      hit_way = -1;
      r       = '0;
      access_cnt = access_cnt + 1'b1;
      for (w = 0; w < N_WAYS; w++) begin
         if (hit_way < 0 && line_valid[set_idx][w] && line_tag[set_idx][w] == tag) begin
            hit_way = w;
         end
      end
      if (op == OP_WRITE) begin
         if (hit_way >= 0) begin
            line_bytes[set_idx][hit_way][offs] = data;
         end else begin
            miss_cnt = miss_cnt + 1'b1;
         end
         shadow_mem[addr] = data;
      end else begin
         victim = hit_way;
         if (hit_way < 0) begin
            miss_cnt = miss_cnt + 1'b1;
            for (w = 0; w < N_WAYS; w++) begin
               if (victim < 0 && !line_valid[set_idx][w]) begin
                  victim = w;
               end
            end
            if (victim < 0) begin
               victim = evict_ptr[set_idx];
               evict_ptr[set_idx] = (victim + 1) % N_WAYS;
               n_evictions++;
            end
            for (k = 0; k < LINE_LEN; k++) begin
               line_bytes[set_idx][victim][k] = shadow_mem[base + ADDR_W'(k)];
            end
            line_tag[set_idx][victim] = tag;
            line_valid[set_idx][victim] = 1'b1;
         end
         r.read_data = line_bytes[set_idx][victim][offs];
      end
      r.hit = (hit_way >= 0);
      r.access_total = access_cnt;
      r.miss_total = miss_cnt;
      return r;
   endfunction

   task automatic add_item(op_type op, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
      access_item_type item;
      item.op = op;
      item.addr = addr;
      item.data = data;
      pending_q.push_back(item);
   endtask

   task automatic report_error(string what, longint want, longint got);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("ERROR cycle %0d: %s expected 0x%0h got 0x%0h", cycle_count, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles: %0d of %0d transactions checked",
                  cycle_count, n_checked, n_accepted);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Request driver. A new transaction is only picked up once the previous one
   // has been accepted, so valid and payload stay put while the block stalls.
   always @(posedge clock) begin : req_driver
      access_item_type item;
      bit              idle;
      bit              wait_drain;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         idle = ($urandom_range(0, 99) < 14) && !(n_offered >= QUIET_LO && n_offered < QUIET_HI);
         wait_drain = (n_offered == PAUSE_AT) && (n_checked != n_offered);
         if (pending_q.size() != 0 && !idle && !wait_drain) begin
            item = pending_q.pop_front();
            req_valid <= 1'b1;
            req_mode <= item.op;
            req_address <= item.addr;
            req_write_data <= item.data;
            n_offered <= n_offered + 1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response sink with random stalls and one long hold-off.
   always @(posedge clock) begin : rsp_sink
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (!hold_done && n_taken == HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !(($urandom_range(0, 99) < 14) &&
                           !(n_taken >= QUIET_LO && n_taken < QUIET_HI));
         end
         if (rsp_valid && rsp_ready) begin
            n_taken <= n_taken + 1;
         end
      end
   end

   // Predicts each accepted request and checks each delivered response in order.
   always @(posedge clock) begin : scoreboard
      access_result_type want;
      access_result_type got;
      if (!reset) begin
         if (req_valid && req_ready) begin
            want = cache_access(op_type'(req_mode), req_address, req_write_data);
            expected_q.push_back(want);
            n_accepted <= n_accepted + 1;
            if (req_mode == OP_WRITE) begin
               n_writes++;
            end else begin
               n_reads++;
            end
            if (want.hit) begin
               n_hits++;
            end
         end
         if (rsp_valid && rsp_ready) begin
            got.read_data = rsp_read_data;
            got.hit = rsp_hit;
            got.access_total = rsp_access_total;
            got.miss_total = rsp_miss_total;
            if (expected_q.size() == 0) begin
               report_error("unexpected response, access_total", 0, got.access_total);
            end else begin
               want = expected_q.pop_front();
               if (got.read_data !== want.read_data) begin
                  report_error("read_data", want.read_data, got.read_data);
               end
               if (got.hit !== want.hit) begin
                  report_error("hit", want.hit, got.hit);
               end
               if (got.access_total !== want.access_total) begin
                  report_error("access_total", want.access_total, got.access_total);
               end
               if (got.miss_total !== want.miss_total) begin
                  report_error("miss_total", want.miss_total, got.miss_total);
               end
               n_checked <= n_checked + 1;
            end
         end
      end
   end

   initial begin
      int                tag_pool [N_SETS][TAGS_PER_SET];
      int                total;
      int                i;
      int                s;
      int                t;
      logic [ADDR_W-1:0] addr;
      op_type            op;

      for (i = 0; i < MEM_LEN; i++) begin
         shadow_mem[i] = '0;
      end
      for (s = 0; s < N_SETS; s++) begin
         evict_ptr[s] = 0;
         for (t = 0; t < N_WAYS; t++) begin
            line_valid[s][t] = 1'b0;
         end
      end

      // Directed part: extremes, write-through, no-allocate and FIFO eviction.
      add_item(OP_READ,  16'h0000, 8'h00);
      add_item(OP_WRITE, 16'h0000, 8'hFF);
      add_item(OP_READ,  16'h0000, 8'h00);
      add_item(OP_WRITE, 16'hFFFF, 8'hA5);
      add_item(OP_READ,  16'hFFFF, 8'h00);
      add_item(OP_READ,  16'hFFFF, 8'h00);
      add_item(OP_WRITE, 16'hFFC0, 8'h5A);
      add_item(OP_READ,  16'hFFC0, 8'hFF);
      // Fill set 0 from way 0 upward, then keep replacing the oldest line.
      add_item(OP_READ,  byte_addr(1, 0, 1), 8'h00);
      add_item(OP_READ,  byte_addr(2, 0, 2), 8'h00);
      add_item(OP_READ,  byte_addr(3, 0, LINE_LEN - 1), 8'h00);
      add_item(OP_READ,  byte_addr(4, 0, 4), 8'h00);
      add_item(OP_READ,  16'h0000, 8'h00);
      add_item(OP_WRITE, byte_addr(1, 0, 1), 8'h3C);
      add_item(OP_READ,  byte_addr(1, 0, 1), 8'h00);
      add_item(OP_WRITE, byte_addr(4, 0, 4), 8'hC3);
      add_item(OP_READ,  byte_addr(4, 0, 4), 8'h00);
      add_item(OP_WRITE, byte_addr(127, 7, 0), 8'h01);
      add_item(OP_WRITE, byte_addr(127, 7, LINE_LEN - 1), 8'h80);
      add_item(OP_READ,  byte_addr(127, 7, 0), 8'h00);
      add_item(OP_READ,  byte_addr(127, 7, LINE_LEN - 1), 8'h00);

      // Random part: mostly a small tag pool per set so lines get reused and
      // evicted, the rest spread over the whole address space.
      for (s = 0; s < N_SETS; s++) begin
         for (t = 0; t < TAGS_PER_SET; t++) begin
            tag_pool[s][t] = $urandom_range(0, (1 << TAG_W) - 1);
         end
      end
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         op = ($urandom_range(0, 99) < 40) ? OP_WRITE : OP_READ;
         if ($urandom_range(0, 99) < 75) begin
            s = $urandom_range(0, N_SETS - 1);
            addr = byte_addr(tag_pool[s][$urandom_range(0, TAGS_PER_SET - 1)], s,
                             $urandom_range(0, LINE_LEN - 1));
         end else begin
            addr = ADDR_W'($urandom_range(0, MEM_LEN - 1));
         end
         add_item(op, addr, DATA_W'($urandom_range(0, 255)));
      end
      total = pending_q.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      do begin
         @(negedge clock);
      end while (n_accepted != total || expected_q.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      while (expected_q.size() != 0) begin
         report_error("missing response, access_total", expected_q[0].access_total, 0);
         void'(expected_q.pop_front());
      end

      $display("Checked %0d transactions: %0d reads, %0d writes, %0d hits, %0d line evictions.",
               n_checked, n_reads, n_writes, n_hits, n_evictions);
      $display("Exercised a %0d-cycle response hold-off and a full drain pause; %0d errors.",
               HOLD_CYCLES, error_count);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/safc_pkg.sv
hdl/safc_ctrl.sv
hdl/safc_dp.sv
hdl/set_assoc_cache_fifo_core.sv
tb/set_assoc_cache_fifo_core_test.sv
